// ===== hw/rtl/urdp_pkg.sv =====
package urdp_pkg;

  // Default store depth and the fixed widths of the item fields.
  localparam int unsigned POOL_SIZE_DEF = 1024;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned RND_W         = 16;
  localparam int unsigned ACT_W         = 2;
  localparam int unsigned PROD_W        = RND_W + CNT_W;

  // Configuration register indexes.
  localparam logic CFG_RANGE_START = 1'b0;
  localparam logic CFG_RANGE_COUNT = 1'b1;

  // Operations carried with each input word.
  typedef enum logic [ACT_W-1:0] {
    ACT_DRAW    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_INIT    = 2'd2
  } action_e;

  // One finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic [VAL_W-1:0] drawn_value;
    logic             status;
    logic [CNT_W-1:0] remaining;
    logic             exhausted;
  } result_t;

endpackage

// ===== hw/rtl/urdp_store.sv =====
module urdp_store #(
  parameter int unsigned DEPTH = urdp_pkg::POOL_SIZE_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [AW-1:0] rdata_a_o,
  output logic [AW-1:0] rdata_b_o
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_a_q;
  logic [AW-1:0] rdata_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/urdp_seq.sv =====
module urdp_seq #(
  parameter int unsigned POOL_SIZE = urdp_pkg::POOL_SIZE_DEF,
  parameter int unsigned AW        = $clog2(POOL_SIZE)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Item from the input channel.
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  logic [urdp_pkg::ACT_W-1:0]  action_i,
  input  logic [urdp_pkg::RND_W-1:0]  random_value_i,
  // Configuration values.
  input  logic [urdp_pkg::VAL_W-1:0]  range_start_i,
  input  logic [urdp_pkg::CNT_W-1:0]  range_count_i,
  // Store access.
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [AW-1:0]               mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_a_o,
  output logic [AW-1:0]               mem_raddr_b_o,
  input  logic [AW-1:0]               mem_rdata_a_i,
  input  logic [AW-1:0]               mem_rdata_b_i,
  // Finished result.
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output urdp_pkg::result_t           res_o
);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_MUL,
    S_READ,
    S_WRA,
    S_WRB,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic [AW-1:0]                  fill_q;
  logic                           fill_reply_q;
  logic [urdp_pkg::CNT_W-1:0]     unused_q;
  logic [urdp_pkg::RND_W-1:0]     rnd_q;
  logic [AW-1:0]                  pick_q;
  logic [AW-1:0]                  val_q;
  logic [urdp_pkg::VAL_W-1:0]     drawn_q;
  logic                           status_q;

  logic [urdp_pkg::CNT_W-1:0]     restart_count;
  logic [urdp_pkg::PROD_W-1:0]    product;
  logic [AW-1:0]                  last_idx;
  logic                           accept;

  // Restart loads the range count, saturated to the store depth.
  assign restart_count = ({21'd0, range_count_i} > 32'(POOL_SIZE))
                       ? urdp_pkg::CNT_W'(POOL_SIZE) : range_count_i;

  // Single multiplier: pick = (random * unused) >> 16.
  assign product  = urdp_pkg::PROD_W'(rnd_q) * urdp_pkg::PROD_W'(unused_q);
  assign last_idx = AW'(unused_q - urdp_pkg::CNT_W'(1));

  assign item_ready_o = (state_q == S_IDLE);
  assign accept       = item_valid_i && item_ready_o;

  // Store port control: identity fill sweep, then the two swap writes.
  always_comb begin
    mem_we_o      = 1'b0;
    mem_waddr_o   = fill_q;
    mem_wdata_o   = fill_q;
    mem_raddr_a_o = pick_q;
    mem_raddr_b_o = last_idx;
    unique case (state_q)
      S_FILL: begin
        mem_we_o = 1'b1;
      end
      S_WRA: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pick_q;
        mem_wdata_o = mem_rdata_b_i;
      end
      S_WRB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = last_idx;
        mem_wdata_o = val_q;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_FILL;
      fill_q       <= '0;
      fill_reply_q <= 1'b0;
      unused_q     <= '0;
      rnd_q        <= '0;
      pick_q       <= '0;
      val_q        <= '0;
      drawn_q      <= '0;
      status_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_FILL: begin
          fill_q <= fill_q + AW'(1);
          if (fill_q == AW'(POOL_SIZE - 1)) begin
            fill_q       <= '0;
            fill_reply_q <= 1'b0;
            state_q      <= fill_reply_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rnd_q    <= random_value_i;
            drawn_q  <= '0;
            status_q <= 1'b0;
            unique case (urdp_pkg::action_e'(action_i))
              urdp_pkg::ACT_DRAW: begin
                if (unused_q == '0) begin
                  status_q <= 1'b1;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= S_MUL;
                end
              end
              urdp_pkg::ACT_RESTART: begin
                unused_q <= restart_count;
                state_q  <= S_DONE;
              end
              urdp_pkg::ACT_INIT: begin
                unused_q     <= restart_count;
                fill_q       <= '0;
                fill_reply_q <= 1'b1;
                state_q      <= S_FILL;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          pick_q  <= AW'(product[urdp_pkg::PROD_W-1:urdp_pkg::RND_W]);
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_WRA;
        end
        S_WRA: begin
          val_q   <= mem_rdata_a_i;
          state_q <= S_WRB;
        end
        S_WRB: begin
          drawn_q  <= range_start_i + urdp_pkg::VAL_W'(val_q);
          unused_q <= unused_q - urdp_pkg::CNT_W'(1);
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.drawn_value = drawn_q;
  assign res_o.status      = status_q;
  assign res_o.remaining   = unused_q;
  assign res_o.exhausted   = (unused_q == '0);

endmodule

// ===== hw/rtl/unique_random_draw_pool.sv =====
// Draws values from the range [range_start, range_start + range_count) without
// repetition, keeping a partial shuffle of offsets in an internal store.
// Input channel s_axis: tuser carries the action (draw, restart, initialize),
// tdata the 16-bit random word. Output channel m_axis returns one word per
// input word: drawn value, remaining count and exhausted flag in tdata, the
// empty-pool status in tuser. Registers are set through cfg_we_i/cfg_addr_i/
// cfg_wdata_i; the user must do so only while the block is idle, which the
// block itself does not enforce. A draw runs through multiply, a read of both
// entries on the two read ports and two writes on the single store write port,
// then the hand-off to the output register; restart, unknown actions and draws
// on an empty pool go straight to the hand-off.
// Initialize refills the store with its identity, one entry per cycle, and
// then raises output valid. One word is in flight at a time, so the block
// takes no new input word until the result of the last one has moved to the
// output register. After reset the same identity fill runs with s_axis_tready
// low; configuration writes are taken meanwhile.
// The result sits in an output register, so the next word is accepted while
// a result waits; if the receiver stalls longer, the finished result holds
// in the sequencer and s_axis_tready stays low until the output drains.
module unique_random_draw_pool #(
  parameter int unsigned POOL_SIZE = urdp_pkg::POOL_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [urdp_pkg::VAL_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [15:0] random_value
  input  logic [1:0]                 s_axis_tuser,  // [1:0] action
  // Output stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,  // [31:0] drawn_value,
                                                     // [42:32] remaining,
                                                     // [43] exhausted, rest 0
  output logic                       m_axis_tuser   // [0] status
);

  localparam int unsigned AW = $clog2(POOL_SIZE);

  logic [urdp_pkg::VAL_W-1:0] range_start_q;
  logic [urdp_pkg::CNT_W-1:0] range_count_q;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_wdata;
  logic [AW-1:0]              mem_raddr_a;
  logic [AW-1:0]              mem_raddr_b;
  logic [AW-1:0]              mem_rdata_a;
  logic [AW-1:0]              mem_rdata_b;

  logic                       res_valid;
  logic                       res_take;
  urdp_pkg::result_t          res;

  logic                       out_valid_q;
  logic [47:0]                out_data_q;
  logic                       out_user_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        urdp_pkg::CFG_RANGE_START: range_start_q <= cfg_wdata_i;
        urdp_pkg::CFG_RANGE_COUNT: range_count_q <= cfg_wdata_i[urdp_pkg::CNT_W-1:0];
        default: range_start_q <= range_start_q;
      endcase
    end
  end

  urdp_seq #(
    .POOL_SIZE (POOL_SIZE),
    .AW        (AW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s_axis_tvalid),
    .item_ready_o   (s_axis_tready),
    .action_i       (s_axis_tuser),
    .random_value_i (s_axis_tdata),
    .range_start_i  (range_start_q),
    .range_count_i  (range_count_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_a_o  (mem_raddr_a),
    .mem_raddr_b_o  (mem_raddr_b),
    .mem_rdata_a_i  (mem_rdata_a),
    .mem_rdata_b_i  (mem_rdata_b),
    .res_valid_o    (res_valid),
    .res_take_i     (res_take),
    .res_o          (res)
  );

  urdp_store #(
    .DEPTH (POOL_SIZE),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Output register: loads a waiting result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {4'd0, res.exhausted, res.remaining, res.drawn_value};
        out_user_q  <= res.status;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The exhausted flag always agrees with the remaining count.
  a_exhausted_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[43] == (m_axis_tdata[42:32] == 11'd0)))
    else $error("exhausted flag disagrees with remaining count");

  // A failed draw never carries a value.
  a_status_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("exhausted draw returned a nonzero value");

  // The pool never reports more entries than the store holds.
  a_remaining_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[42:32]) <= 32'(POOL_SIZE)))
    else $error("remaining count exceeds the store depth");

  // Store writes stay within the store.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < 32'(POOL_SIZE)))
    else $error("store write beyond the pool");

endmodule

// ===== dv/draw_pool_monitor.sv =====
`timescale 1ns / 100ps

// Watches the register port and both streams of the draw pool. It keeps its own
// copy of the shuffled offset store, predicts one result word per accepted
// input word and compares every returned word with the oldest prediction.
module draw_pool_monitor
  import urdp_pkg::*;
#(
  parameter int unsigned POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [VAL_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [RND_W-1:0] in_random_i,
  input  logic [ACT_W-1:0] in_action_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [47:0]      out_data_i,
  input  logic             out_status_i,
  output int               mismatch_count_o,
  output int               awaited_count_o
);

  localparam int unsigned OFS_W = $clog2(POOL_SIZE);

  // Range registers and the mirrored shuffle state.
  logic [VAL_W-1:0] range_start_q;
  logic [CNT_W-1:0] range_count_q;
  logic [OFS_W-1:0] offset_mirror [POOL_SIZE];
  logic             mirror_marked [POOL_SIZE];
  logic [CNT_W-1:0] unused_q;
  result_t          awaited_results [$];
  int               mismatches;

  // An entry never written since the last initialize holds its own index.
  function automatic logic [OFS_W-1:0] offset_at(input logic [CNT_W-1:0] pos);
    return mirror_marked[pos] ? offset_mirror[pos] : pos[OFS_W-1:0];
  endfunction

  // A restart loads the range size, capped at the store depth.
  function automatic logic [CNT_W-1:0] refill_level();
    return (32'(range_count_q) > 32'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : range_count_q;
  endfunction

  // Applies one input word to the mirrored state and forms its result word.
  task automatic shuffle_step(input logic [ACT_W-1:0] act, input logic [RND_W-1:0] rnd,
                              output result_t res);
    logic [PROD_W-1:0] product;
    logic [CNT_W-1:0]  pick;
    logic [CNT_W-1:0]  tail;
    logic [OFS_W-1:0]  picked_ofs;
    logic [OFS_W-1:0]  tail_ofs;
    res = '0;
    case (act)
      ACT_DRAW: begin
        if (unused_q == '0) begin
          res.status = 1'b1;
        end else begin
          product    = PROD_W'(rnd) * PROD_W'(unused_q);
          pick       = product[PROD_W-1:RND_W];
          tail       = unused_q - CNT_W'(1);
          picked_ofs = offset_at(pick);
          tail_ofs   = offset_at(tail);
          // Swap the picked entry with the last unused one.
          offset_mirror[pick] = tail_ofs;
          mirror_marked[pick] = 1'b1;
          offset_mirror[tail] = picked_ofs;
          mirror_marked[tail] = 1'b1;
          unused_q            = tail;
          res.drawn_value     = range_start_q + VAL_W'(picked_ofs);
        end
      end
      ACT_RESTART: begin
        unused_q = refill_level();
      end
      ACT_INIT: begin
        for (int i = 0; i < POOL_SIZE; i++) mirror_marked[i] = 1'b0;
        unused_q = refill_level();
      end
      default: begin
        // The spare action code leaves the pool as it is.
      end
    endcase
    res.remaining = unused_q;
    res.exhausted = (unused_q == '0);
  endtask

  task automatic check_field(input string field, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
    end
  endtask

  // Register writes, returned words and accepted words, in that order per edge.
  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t predicted;
    result_t oldest;
    if (!rst_ni) begin
      range_start_q = '0;
      range_count_q = '0;
      unused_q      = '0;
      for (int i = 0; i < POOL_SIZE; i++) mirror_marked[i] = 1'b0;
      awaited_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      awaited_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_RANGE_START) begin
          range_start_q = cfg_wdata_i;
        end else begin
          range_count_q = cfg_wdata_i[CNT_W-1:0];
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $error("result word returned with no prediction waiting");
        end else begin
          oldest = awaited_results.pop_front();
          check_field("drawn_value", oldest.drawn_value, out_data_i[31:0]);
          check_field("status", VAL_W'(oldest.status), VAL_W'(out_status_i));
          check_field("remaining", VAL_W'(oldest.remaining), VAL_W'(out_data_i[42:32]));
          check_field("exhausted", VAL_W'(oldest.exhausted), VAL_W'(out_data_i[43]));
        end
      end

      if (in_valid_i && in_ready_i) begin
        shuffle_step(in_action_i, in_random_i, predicted);
        awaited_results.push_back(predicted);
      end

      mismatch_count_o <= mismatches;
      awaited_count_o  <= awaited_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import urdp_pkg::*;

  localparam int unsigned       POOL_SIZE     = POOL_SIZE_DEF;
  localparam logic [ACT_W-1:0]  ACT_UNUSED    = 2'd3;
  localparam int                RANDOM_ITEMS  = 550;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                STALL_LIMIT   = 8000;
  localparam int                SETTLE_CYCLES = 8;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_addr_i    = 1'b0;
  logic [VAL_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;
  logic [1:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;
  logic             m_axis_tuser;

  int sender_idle_pct   = 36;
  int receiver_idle_pct = 36;
  int hold_requests     = 0;
  int holds_served      = 0;
  int random_items      = 0;
  int idle_cycles       = 0;
  int level_now         = 0;
  int mismatch_count;
  int awaited_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  unique_random_draw_pool #(
    .POOL_SIZE(POOL_SIZE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  draw_pool_monitor #(
    .POOL_SIZE(POOL_SIZE)
  ) u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_random_i     (s_axis_tdata),
    .in_action_i     (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_status_i    (m_axis_tuser),
    .mismatch_count_o(mismatch_count),
    .awaited_count_o (awaited_count)
  );

  // Offers one word, after a random gap, and waits until it is taken.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [RND_W-1:0] rnd);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= rnd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every predicted word has come back.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both range registers on consecutive edges.
  task automatic set_range(input logic [VAL_W-1:0] first_value,
                           input logic [CNT_W-1:0] value_count);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_RANGE_START;
    cfg_wdata_i <= first_value;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_RANGE_COUNT;
    cfg_wdata_i <= VAL_W'(value_count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    level_now = (value_count > POOL_SIZE) ? POOL_SIZE : value_count;
  endtask

  // Receiver: random back-pressure, plus one long hold-off when requested.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_requests > holds_served) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Ends the run when no word moves on either stream for too long.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("unique_random_draw_pool test failed");
    $finish;
  end

  initial begin : stimulus
    int               phase;
    int               seq_left;
    int               draws;
    int               roll;
    logic [VAL_W-1:0] first_value;
    logic [CNT_W-1:0] value_count;
    logic [RND_W-1:0] rnd;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Small range whose top end wraps past zero; start on an empty pool.
    set_range(32'hFFFF_FFFE, 11'd4);
    send_word(ACT_DRAW, 16'h1234);
    send_word(ACT_UNUSED, 16'hFFFF);
    send_word(ACT_RESTART, 16'h0000);
    send_word(ACT_DRAW, 16'h0000);
    send_word(ACT_DRAW, 16'hFFFF);
    send_word(ACT_DRAW, 16'h8000);
    send_word(ACT_DRAW, 16'hFFFF);
    send_word(ACT_DRAW, 16'hA5A5);
    send_word(ACT_UNUSED, 16'h0000);
    send_word(ACT_RESTART, 16'hFFFF);
    send_word(ACT_DRAW, 16'hFFFF);
    send_word(ACT_DRAW, 16'h0000);
    quiesce();

    // Oversized count saturates; restart keeps the earlier permutation.
    set_range(32'h8000_0000, 11'h7FF);
    send_word(ACT_RESTART, 16'h5A5A);
    send_word(ACT_DRAW, 16'hFFFF);
    send_word(ACT_DRAW, 16'h0000);
    send_word(ACT_INIT, 16'hFFFF);
    send_word(ACT_DRAW, 16'hFFFF);
    send_word(ACT_DRAW, 16'h5555);
    quiesce();

    // Empty range.
    set_range(32'h7FFF_FFFF, 11'd0);
    send_word(ACT_RESTART, 16'h0001);
    send_word(ACT_DRAW, 16'h7FFF);
    send_word(ACT_INIT, 16'h0000);

    // Random phases, own range each; a few runs, each may restart or init first.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiesce();
      case ($urandom_range(0, 6))
        0: first_value = 32'h8000_0000;
        1: first_value = 32'h7FFF_FFFF;
        2: first_value = '1;
        3: first_value = '0;
        4: first_value = 32'hFFFF_FF00;
        default: first_value = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0: value_count = 11'd0;
        1: value_count = 11'd1;
        2: value_count = 11'd2;
        3: value_count = CNT_W'(POOL_SIZE);
        4: value_count = 11'h7FF;
        5: value_count = CNT_W'($urandom_range(41, POOL_SIZE));
        default: value_count = CNT_W'($urandom_range(3, 40));
      endcase
      // The first phase runs without any gaps and carries the long receiver hold-off.
      if (phase == 0) value_count = 11'd48;
      set_range(first_value, value_count);
      sender_idle_pct   = (phase == 0) ? 0 : 36;
      receiver_idle_pct = (phase == 0) ? 0 : 36;

      seq_left = $urandom_range(2, 5);
      while (seq_left > 0 && random_items < RANDOM_ITEMS) begin
        seq_left--;
        roll = $urandom_range(0, 99);
        if (roll < 25 && phase != 0) begin
          send_word(ACT_INIT, RND_W'($urandom()));
          random_items++;
        end else if (roll < 90) begin
          send_word(ACT_RESTART, RND_W'($urandom()));
          random_items++;
        end
        // Otherwise the draws carry on from whatever is left of the pool.
        draws = $urandom_range(0, ((level_now < 60) ? level_now : 60) + 2);
        if (phase == 0 && draws < 10) draws = 10;
        for (int j = 0; j < draws; j++) begin
          if (j == 1 && draws >= 10 && phase == 0 && hold_requests == 0) hold_requests++;
          case ($urandom_range(0, 6))
            0: rnd = '0;
            1: rnd = '1;
            default: rnd = RND_W'($urandom());
          endcase
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            send_word(ACT_UNUSED, rnd);
          end else if (roll < 6) begin
            send_word(ACT_RESTART, rnd);
            random_items++;
          end else begin
            send_word(ACT_DRAW, rnd);
            random_items++;
          end
        end
      end
      phase++;
    end

    quiesce();
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("unique_random_draw_pool test passed");
    end else begin
      $display("unique_random_draw_pool test failed");
    end
    $finish;
  end

endmodule
